@@ hdl/pas_pkg.sv @@
// ----------------------------------------------------------------------------
// pas_pkg
// Types and constants shared by the polar angle point sort block.
// ----------------------------------------------------------------------------
package pas_pkg;

   localparam int COORD_W = 16;
   localparam int IDX_W   = 5;

   // one request: a point of the polygon
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      last_point;
   } pas_req_type;

   // one result: a sorted point
   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic        [IDX_W-1:0]   arrival_index;
      logic                      last_out;
   } pas_rsp_type;

   // one entry of the point store
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic        [IDX_W-1:0]   idx;
   } pas_entry_type;

   // status of the shared compare unit
   typedef struct packed {
      logic done;
      logic ahead;
   } pas_cmp_status_type;

endpackage

@@ hdl/pas_cmp.sv @@
// ----------------------------------------------------------------------------
// pas_cmp
// Ordering compare of two points about the pivot, worked out on one shared
// 17x17 multiplier and an accumulator: cross product first, squared
// distances only when the cross product is zero. The result is ready after
// the cross product, or after the distances if collinear with the pivot.
// ----------------------------------------------------------------------------
module pas_cmp
   import pas_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W-1:0] pivot_x,
   input  logic signed [COORD_W-1:0] pivot_y,
   input  logic signed [COORD_W-1:0] a_x,
   input  logic signed [COORD_W-1:0] a_y,
   input  logic signed [COORD_W-1:0] b_x,
   input  logic signed [COORD_W-1:0] b_y,
   output pas_cmp_status_type        status
);

   localparam int DW   = COORD_W + 1;
   localparam int PW   = 2 * DW;
   localparam int ACCW = PW + 2;

   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_CR1   = 4'd1;
   localparam logic [3:0] PH_CR2   = 4'd2;
   localparam logic [3:0] PH_CRACC = 4'd3;
   localparam logic [3:0] PH_CHK   = 4'd4;
   localparam logic [3:0] PH_SQ2   = 4'd5;
   localparam logic [3:0] PH_SQ3   = 4'd6;
   localparam logic [3:0] PH_SQ4   = 4'd7;
   localparam logic [3:0] PH_SQACC = 4'd8;
   localparam logic [3:0] PH_FIN   = 4'd9;

   logic [3:0]             ph_ff, ph_in;
   logic signed [DW-1:0]   ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [PW-1:0]   prod_ff;
   logic                   pv_ff, pv_in;
   logic                   neg_ff, neg_in;
   logic signed [ACCW-1:0] acc_ff, acc_in;
   logic signed [DW-1:0]   op_a, op_b;
   logic                   acc_clear;
   logic                   cross_zero;

   assign cross_zero = (acc_ff == '0);

   always_comb begin
      op_a      = '0;
      op_b      = '0;
      pv_in     = 1'b0;
      neg_in    = 1'b0;
      acc_clear = 1'b0;
      ph_in     = ph_ff;
      case (ph_ff)
         PH_IDLE: begin
            if (start) begin
               ph_in     = PH_CR1;
               acc_clear = 1'b1;
            end
         end
         PH_CR1: begin
            op_a  = ax_ff;
            op_b  = by_ff;
            pv_in = 1'b1;
            ph_in = PH_CR2;
         end
         PH_CR2: begin
            op_a   = bx_ff;
            op_b   = ay_ff;
            pv_in  = 1'b1;
            neg_in = 1'b1;
            ph_in  = PH_CRACC;
         end
         PH_CRACC: begin
            ph_in = PH_CHK;
         end
         PH_CHK: begin
            if (cross_zero) begin
               // collinear: compare squared distances instead
               op_a      = ax_ff;
               op_b      = ax_ff;
               pv_in     = 1'b1;
               acc_clear = 1'b1;
               ph_in     = PH_SQ2;
            end else begin
               ph_in = PH_IDLE;
            end
         end
         PH_SQ2: begin
            op_a  = ay_ff;
            op_b  = ay_ff;
            pv_in = 1'b1;
            ph_in = PH_SQ3;
         end
         PH_SQ3: begin
            op_a   = bx_ff;
            op_b   = bx_ff;
            pv_in  = 1'b1;
            neg_in = 1'b1;
            ph_in  = PH_SQ4;
         end
         PH_SQ4: begin
            op_a   = by_ff;
            op_b   = by_ff;
            pv_in  = 1'b1;
            neg_in = 1'b1;
            ph_in  = PH_SQACC;
         end
         PH_SQACC: begin
            ph_in = PH_FIN;
         end
         PH_FIN: begin
            ph_in = PH_IDLE;
         end
         default: begin
            ph_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (pv_ff) begin
         if (neg_ff) begin
            acc_in = acc_ff - ACCW'(prod_ff);
         end else begin
            acc_in = acc_ff + ACCW'(prod_ff);
         end
      end
   end

   always_comb begin
      status.done  = ((ph_ff == PH_CHK) && !cross_zero) || (ph_ff == PH_FIN);
      status.ahead = (ph_ff == PH_CHK) ? !acc_ff[ACCW-1] : acc_ff[ACCW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         pv_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         pv_ff <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      prod_ff <= PW'(op_a) * PW'(op_b);
      acc_ff  <= acc_in;
      if (start && (ph_ff == PH_IDLE)) begin
         ax_ff <= DW'(a_x) - DW'(pivot_x);
         ay_ff <= DW'(a_y) - DW'(pivot_y);
         bx_ff <= DW'(b_x) - DW'(pivot_x);
         by_ff <= DW'(b_y) - DW'(pivot_y);
      end
   end

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      start |-> (ph_ff == PH_IDLE))
      else $error("compare started while busy");

   a_done_ends : assert property (@(posedge clock) disable iff (reset)
      status.done |=> (ph_ff == PH_IDLE))
      else $error("compare did not return to idle after done");

   a_collinear_path : assert property (@(posedge clock) disable iff (reset)
      ((ph_ff == PH_CHK) && cross_zero) |=> ((ph_ff == PH_SQ2) && (acc_ff == '0)))
      else $error("distance pass not entered with a cleared accumulator");

endmodule

@@ hdl/polar_angle_point_sort.sv @@
// ----------------------------------------------------------------------------
// polar_angle_point_sort
// Sorts a polygon's points counterclockwise about the first point (pivot),
// collinear points nearer first, and plays them back in sorted order.
// ----------------------------------------------------------------------------
// Usage: present a point on req_point and raise start; the request is taken
// at a clock edge with start high and busy low. The first point of a run is
// the pivot and, unless last_point is set, leaves busy low, so the next
// request can follow at once. Each later point is inserted into the point
// store: a scan compares it with stored points 1, 2 and onward until it goes
// before one; each step is a store read, a compare start and a wait on the
// shared compare unit, longer when collinear with the pivot. Then a shift
// moves the entries above up, each by a read and a write, and a final write
// stores the point. Once the store holds MAX_POINTS points, further points
// are dropped. A request with last_point set also starts playback: one
// result per stored point on consecutive cycles, rsp_valid high for exactly
// one cycle each, registered alongside its store read; last_out marks the
// final one. The receiver cannot stall, so results must be taken as shown.
// busy stays high from the request until the final read of playback.
// Reset clears the point count and the sequencer; the store is not cleared.
// ----------------------------------------------------------------------------
module polar_angle_point_sort
   import pas_pkg::*;
#(
   parameter int MAX_POINTS = 32
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  pas_req_type req_point,
   output logic        busy,
   output logic        rsp_valid,
   output pas_rsp_type rsp_point
);

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int AW = $clog2(MAX_POINTS);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN_RD  = 3'd1;
   localparam logic [2:0] ST_SCAN_CMP = 3'd2;
   localparam logic [2:0] ST_SCAN_WT  = 3'd3;
   localparam logic [2:0] ST_SHIFT_RD = 3'd4;
   localparam logic [2:0] ST_SHIFT_WR = 3'd5;
   localparam logic [2:0] ST_OUT      = 3'd6;

   logic [2:0]                state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             i_ff, i_in;
   logic [CW-1:0]             pos_ff, pos_in;
   logic [CW-1:0]             i_inc, i_dec;
   logic [CW+IDX_W-1:0]       count_ext;
   pas_entry_type             np_ff, np_in;
   logic                      last_ff, last_in;
   logic signed [COORD_W-1:0] pivot_x_ff, pivot_y_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_last_ff, rsp_last_in;

   pas_entry_type             mem [MAX_POINTS];
   pas_entry_type             rd_ff;
   logic                      we;
   logic [AW-1:0]             wa;
   pas_entry_type             wd;
   logic [AW-1:0]             ra;

   logic                      cmp_start;
   pas_cmp_status_type        cmp_status;

   assign busy      = (state_ff != ST_IDLE);
   assign i_inc     = CW'(i_ff + 1'b1);
   assign i_dec     = CW'(i_ff - 1'b1);
   assign count_ext = {{IDX_W{1'b0}}, count_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      pos_in       = pos_ff;
      np_in        = np_ff;
      last_in      = last_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      we           = 1'b0;
      wa           = '0;
      wd           = np_ff;
      ra           = i_ff[AW-1:0];
      cmp_start    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               np_in.x   = req_point.x;
               np_in.y   = req_point.y;
               np_in.z   = req_point.z;
               np_in.idx = count_ext[IDX_W-1:0];
               last_in   = req_point.last_point;
               i_in      = '0;
               if (count_ff < CW'(MAX_POINTS)) begin
                  if (count_ff == '0) begin
                     // the pivot goes straight into entry zero
                     we       = 1'b1;
                     wa       = '0;
                     wd       = np_in;
                     count_in = CW'(1);
                     state_in = req_point.last_point ? ST_OUT : ST_IDLE;
                  end else begin
                     i_in     = CW'(1);
                     state_in = ST_SCAN_RD;
                  end
               end else if (req_point.last_point) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_SCAN_RD: begin
            if (i_ff == count_ff) begin
               // goes after every stored point
               pos_in   = count_ff;
               state_in = ST_SHIFT_RD;
            end else begin
               ra       = i_ff[AW-1:0];
               state_in = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            cmp_start = 1'b1;
            state_in  = ST_SCAN_WT;
         end
         ST_SCAN_WT: begin
            if (cmp_status.done) begin
               if (cmp_status.ahead) begin
                  pos_in   = i_ff;
                  i_in     = count_ff;
                  state_in = ST_SHIFT_RD;
               end else begin
                  i_in     = i_inc;
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SHIFT_RD: begin
            if (i_ff > pos_ff) begin
               ra       = i_dec[AW-1:0];
               state_in = ST_SHIFT_WR;
            end else begin
               we       = 1'b1;
               wa       = pos_ff[AW-1:0];
               wd       = np_ff;
               count_in = CW'(count_ff + 1'b1);
               i_in     = '0;
               state_in = last_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_SHIFT_WR: begin
            we       = 1'b1;
            wa       = i_ff[AW-1:0];
            wd       = rd_ff;
            i_in     = i_dec;
            state_in = ST_SHIFT_RD;
         end
         ST_OUT: begin
            // one read a cycle, the result strobes out in the cycle after
            ra           = i_ff[AW-1:0];
            rsp_valid_in = 1'b1;
            rsp_last_in  = (i_inc == count_ff);
            if (i_inc == count_ff) begin
               count_in = '0;
               state_in = ST_IDLE;
            end else begin
               i_in = i_inc;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      pos_ff      <= pos_in;
      np_ff       <= np_in;
      last_ff     <= last_in;
      rsp_last_ff <= rsp_last_in;
      if ((state_ff == ST_IDLE) && start && (count_ff == '0)) begin
         pivot_x_ff <= req_point.x;
         pivot_y_ff <= req_point.y;
      end
   end

   // point store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   pas_cmp u_cmp (
      .clock   (clock),
      .reset   (reset),
      .start   (cmp_start),
      .pivot_x (pivot_x_ff),
      .pivot_y (pivot_y_ff),
      .a_x     (np_ff.x),
      .a_y     (np_ff.y),
      .b_x     (rd_ff.x),
      .b_y     (rd_ff.y),
      .status  (cmp_status)
   );

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_point.out_x         = rd_ff.x;
   assign rsp_point.out_y         = rd_ff.y;
   assign rsp_point.out_z         = rd_ff.z;
   assign rsp_point.arrival_index = rd_ff.idx;
   assign rsp_point.last_out      = rsp_last_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond store depth");

   a_last_gap : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_point.last_out) |=> !rsp_valid)
      else $error("result strobe straight after the final result");

   a_cmp_done_scan : assert property (@(posedge clock) disable iff (reset)
      cmp_status.done |-> (state_ff == ST_SCAN_WT))
      else $error("compare finished outside the scan");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT_RD) |-> ((pos_ff != '0) && (pos_ff <= count_ff)))
      else $error("insert position out of range");

endmodule

@@ bench/polar_angle_point_sort_tb.sv @@
// ----------------------------------------------------------------------------
// polar_angle_point_sort_tb
// Loads polygons one point per request and checks the sorted playback
// against an in-bench insertion sort with the same ordering rules. A short
// table covers single points, collinear points, exact ties, points on the
// pivot and the coordinate extremes. Random polygons follow, among them one
// that overflows the point store and one that fills it exactly.
// ----------------------------------------------------------------------------
module polar_angle_point_sort_tb;
   import pas_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_POINTS = 32;
   localparam int DIR_ROWS   = 21;
   localparam int RAND_ITEMS = 110;

   typedef struct packed {
      pas_req_type pt;
      logic        typed;
      pas_rsp_type want;
   } dir_row_type;

   // single points carry their result, two of them at the extremes; the rest go to the sort
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{'{16'h8000, 16'h7FFF, 16'h8000, 1'b1}, 1'b1,
        '{16'h8000, 16'h7FFF, 16'h8000, 5'd0, 1'b1}},
      '{'{16'h7FFF, 16'h8000, 16'h7FFF, 1'b1}, 1'b1,
        '{16'h7FFF, 16'h8000, 16'h7FFF, 5'd0, 1'b1}},
      '{'{16'sd0, 16'sd0, -16'sd1, 1'b1}, 1'b1, '{16'sd0, 16'sd0, -16'sd1, 5'd0, 1'b1}},
      // pivot at the origin, collinear points, a repeat and a point on the pivot
      '{'{16'sd0, 16'sd0, 16'sd11, 1'b0}, 1'b0, '0},
      '{'{16'sd100, 16'sd0, 16'sd12, 1'b0}, 1'b0, '0},
      '{'{16'sd0, 16'sd100, 16'sd13, 1'b0}, 1'b0, '0},
      '{'{16'sd50, 16'sd0, 16'sd14, 1'b0}, 1'b0, '0},
      '{'{-16'sd100, 16'sd0, 16'sd15, 1'b0}, 1'b0, '0},
      '{'{16'sd0, -16'sd100, 16'sd16, 1'b0}, 1'b0, '0},
      '{'{16'sd100, 16'sd100, 16'sd17, 1'b0}, 1'b0, '0},
      '{'{16'sd50, 16'sd0, 16'sd18, 1'b0}, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 16'sd19, 1'b0}, 1'b0, '0},
      '{'{-16'sd50, -16'sd50, 16'sd20, 1'b1}, 1'b0, '0},
      // pivot in the most negative corner, widest differences
      '{'{16'h8000, 16'h8000, 16'h7FFF, 1'b0}, 1'b0, '0},
      '{'{16'h7FFF, 16'h7FFF, 16'sd1, 1'b0}, 1'b0, '0},
      '{'{16'h7FFF, 16'h8000, 16'sd2, 1'b0}, 1'b0, '0},
      '{'{16'h8000, 16'h7FFF, 16'sd3, 1'b0}, 1'b0, '0},
      '{'{16'h8000, 16'h8000, 16'sd4, 1'b0}, 1'b0, '0},
      '{'{16'sd0, 16'sd0, 16'sd5, 1'b1}, 1'b0, '0},
      '{'{16'h7FFF, 16'h7FFF, -16'sd2, 1'b0}, 1'b0, '0},
      '{'{16'h8000, 16'h8000, 16'h8000, 1'b1}, 1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        start;
   pas_req_type req_point;
   logic        busy;
   logic        rsp_valid;
   pas_rsp_type rsp_point;

   pas_entry_type sorted_store [MAX_POINTS];
   int unsigned   stored_count;
   pas_rsp_type   sorted_points_due [$];
   pas_rsp_type   want;
   pas_req_type   run_pivot;
   pas_req_type   prev_point;
   bit            burst_mode;
   int unsigned   mismatches;
   int unsigned   points_sent;
   int unsigned   polygons_sent;
   int unsigned   points_checked;

   polar_angle_point_sort #(.MAX_POINTS(MAX_POINTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_point (req_point),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_point (rsp_point)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout: sorter stopped responding");
      $display("Mismatches found");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint exp);
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, exp);
      mismatches++;
   endtask

   // a goes strictly before b: counterclockwise about the pivot, then nearer
   function automatic bit goes_before(input pas_entry_type a, input pas_entry_type b);
      longint ax, ay, bx, by, cr;
      ax = longint'($signed(a.x)) - longint'($signed(sorted_store[0].x));
      ay = longint'($signed(a.y)) - longint'($signed(sorted_store[0].y));
      bx = longint'($signed(b.x)) - longint'($signed(sorted_store[0].x));
      by = longint'($signed(b.y)) - longint'($signed(sorted_store[0].y));
      cr = ax * by - bx * ay;
      if (cr != 0) return cr > 0;
      return (ax * ax + ay * ay) < (bx * bx + by * by);
   endfunction

   task automatic insert_point(input pas_req_type p);
      pas_entry_type e;
      pas_rsp_type   r;
      int unsigned   pos;
      int unsigned   i;
      e.x   = p.x;
      e.y   = p.y;
      e.z   = p.z;
      e.idx = IDX_W'(stored_count);
      // a full store drops the point, a last point still plays back
      if (stored_count < MAX_POINTS) begin
         if (stored_count == 0) begin
            sorted_store[0] = e;
         end else begin
            pos = stored_count;
            for (i = 1; i < stored_count && pos == stored_count; i++)
               if (goes_before(e, sorted_store[i])) pos = i;
            for (i = stored_count; i > pos; i--)
               sorted_store[i] = sorted_store[i-1];
            sorted_store[pos] = e;
         end
         stored_count++;
      end
      if (p.last_point) begin
         for (i = 0; i < stored_count; i++) begin
            r.out_x         = sorted_store[i].x;
            r.out_y         = sorted_store[i].y;
            r.out_z         = sorted_store[i].z;
            r.arrival_index = sorted_store[i].idx;
            r.last_out      = (i + 1 == stored_count);
            sorted_points_due.push_back(r);
         end
         stored_count = 0;
      end
   endtask

   task automatic send_point(input pas_req_type p, input logic typed, input pas_rsp_type exp);
      int unsigned gap;
      int unsigned n0;
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start     <= 1'b1;
      req_point <= p;
      do @(posedge clock); while (busy);
      n0 = sorted_points_due.size();
      insert_point(p);
      if (typed) begin
         while (sorted_points_due.size() > n0) void'(sorted_points_due.pop_back());
         sorted_points_due.push_back(exp);
      end
      points_sent++;
      if (p.last_point) polygons_sent++;
   endtask

   // mix of wide points, points near the pivot, collinear rays and repeats
   function automatic pas_req_type random_point(input bit first, input bit last);
      pas_req_type       p;
      logic [COORD_W-1:0] dx, dy;
      int unsigned       kind, k;
      kind         = $urandom_range(0, 9);
      p.z          = COORD_W'($urandom);
      p.last_point = last;
      if (first || kind < 4) begin
         p.x = COORD_W'($urandom);
         p.y = COORD_W'($urandom);
      end else if (kind < 7) begin
         p.x = run_pivot.x + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
         p.y = run_pivot.y + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
      end else if (kind < 9) begin
         dx  = COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
         dy  = COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
         k   = $urandom_range(1, 6);
         p.x = run_pivot.x + COORD_W'(k) * dx;
         p.y = run_pivot.y + COORD_W'(k) * dy;
      end else begin
         p.x = prev_point.x;
         p.y = prev_point.y;
      end
      return p;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (sorted_points_due.size() == 0) begin
            report_mismatch("sorted point with none due, out_x", rsp_point.out_x, 0);
         end else begin
            want = sorted_points_due.pop_front();
            if (rsp_point.out_x !== want.out_x)
               report_mismatch("out_x", rsp_point.out_x, want.out_x);
            if (rsp_point.out_y !== want.out_y)
               report_mismatch("out_y", rsp_point.out_y, want.out_y);
            if (rsp_point.out_z !== want.out_z)
               report_mismatch("out_z", rsp_point.out_z, want.out_z);
            if (rsp_point.arrival_index !== want.arrival_index)
               report_mismatch("arrival_index", rsp_point.arrival_index,
                               want.arrival_index);
            if (rsp_point.last_out !== want.last_out)
               report_mismatch("last_out", rsp_point.last_out, want.last_out);
         end
         points_checked++;
      end
   end

   initial begin
      pas_req_type p;
      int unsigned run_no;
      int unsigned run_len;
      int unsigned k;
      reset        = 1'b1;
      start        = 1'b0;
      req_point    = '0;
      stored_count = 0;
      burst_mode   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < DIR_ROWS; k++)
         send_point(DIR_TABLE[k].pt, DIR_TABLE[k].typed, DIR_TABLE[k].want);

      // second polygon overflows the store, fifth fills it exactly
      run_no = 0;
      while (points_sent < DIR_ROWS + RAND_ITEMS) begin
         run_len    = (run_no == 1) ? MAX_POINTS + 4 :
                      (run_no == 4) ? MAX_POINTS : $urandom_range(1, 9);
         burst_mode = ($urandom_range(0, 3) == 0);
         for (k = 0; k < run_len; k++) begin
            p = random_point(k == 0, k == run_len - 1);
            if (k == 0) run_pivot = p;
            prev_point = p;
            send_point(p, 1'b0, '0);
         end
         run_no++;
      end
      start <= 1'b0;

      while (sorted_points_due.size() != 0 || busy) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("%0d points sent in %0d polygons, including store overflow and exact fill",
               points_sent, polygons_sent);
      $display("%0d sorted points checked, %0d mismatching fields",
               points_checked, mismatches);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
